// ===== design/srsm_pkg.sv =====
// Package for the sensor range and stuck monitor.
// Holds payload, configuration and control types, codes and width helpers.
// Used by every module of the block; depends on nothing.
package srsm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int SQ_W          = 2 * SAMPLE_W - 1;
    localparam int DEPTH_DEFAULT = 10;

    localparam logic signed [SAMPLE_W-1:0] MIN_VALUE_RESET = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] MAX_VALUE_RESET = 16'sh7FFF;
    localparam logic [CFG_DATA_W-1:0]      NOISE_FLOOR_RESET = 32'd0;
    localparam logic [TIME_W-1:0]          SETTLE_MS_RESET = 32'd30000;

    typedef enum logic
    {
        OP_RESTART = 1'b0,
        OP_SAMPLE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CAUSE_NONE  = 2'd0,
        CAUSE_RANGE = 2'd1,
        CAUSE_STUCK = 2'd2
    } fault_cause_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_MIN_VALUE   = 2'd0,
        CFG_MAX_VALUE   = 2'd1,
        CFG_NOISE_FLOOR = 2'd2,
        CFG_SETTLE_MS   = 2'd3
    } cfg_index_t;

    typedef struct packed
    {
        op_t                  op;
        logic [SAMPLE_W-1:0]  sample;
        logic                 sample_invalid;
        logic [TIME_W-1:0]    now_ms;
    } in_item_t;

    typedef struct packed
    {
        logic          healthy;
        fault_cause_t  fault_cause;
    } out_item_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic [CFG_DATA_W-1:0]      noise_floor;
        logic [TIME_W-1:0]          settle_ms;
    } cfg_t;

    typedef struct packed
    {
        op_t                        op;
        logic                       bad;
        logic signed [SAMPLE_W-1:0] x;
        logic [SQ_W-1:0]            x_sq;
        logic [TIME_W-1:0]          now_ms;
    } smp_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] x;
        logic [SQ_W-1:0]            x_sq;
    } ring_entry_t;

    typedef struct packed
    {
        fault_cause_t cause;
        logic         check;
    } win_ctrl_t;

    function automatic int sum_width(input int depth);
        return SAMPLE_W + $clog2(depth);
    endfunction

    function automatic int sumsq_width(input int depth);
        return SQ_W + $clog2(depth);
    endfunction

endpackage

// ===== design/sensor_range_and_stuck_monitor.sv =====
// Top level of the sensor range and stuck monitor.
// Instantiates srsm_cfg, srsm_front, srsm_window and srsm_judge; uses srsm_pkg.
//
// Each transfer on the input channel is either a restart (clears the window and
// marks the start time) or a sample, and yields exactly one result transfer.
// The block takes one item every cycle while the output is not stalled; each
// item passes the input register, the range check and squaring stage, the
// window stage, the stage that squares and scales the sums, and the compare
// into the result register, and results keep input order. One item per cycle
// holds because the window stage updates the running sum, the running sum of
// squares and the sample ring once per cycle. The ring is a DEPTH-entry
// memory with one write and one registered read port; it needs no clearing
// pass, since slots not yet written since a restart read as zero through the
// fill count. Configuration writes are meant for idle periods.
module sensor_range_and_stuck_monitor
#(
    parameter int DEPTH = srsm_pkg::DEPTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [srsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srsm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  srsm_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output srsm_pkg::out_item_t                out_data
);
    import srsm_pkg::*;

    localparam int SUM_W   = sum_width(DEPTH);
    localparam int SUMSQ_W = sumsq_width(DEPTH);

    cfg_t                    cfg;
    logic                    smp_valid;
    logic                    smp_stall;
    smp_t                    smp;
    logic                    win_valid;
    logic                    win_stall;
    win_ctrl_t               win_ctrl;
    logic signed [SUM_W-1:0] win_sum;
    logic [SUMSQ_W-1:0]      win_sumsq;

    srsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srsm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp)
    );

    srsm_window #(.DEPTH(DEPTH)) u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .cfg       (cfg),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win_ctrl  (win_ctrl),
        .win_sum   (win_sum),
        .win_sumsq (win_sumsq)
    );

    srsm_judge #(.DEPTH(DEPTH)) u_judge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_stall (win_stall),
        .win_ctrl  (win_ctrl),
        .win_sum   (win_sum),
        .win_sumsq (win_sumsq),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/srsm_cfg.sv =====
// Configuration registers of the sensor range and stuck monitor.
// Decodes the plain write port into the four settings; uses srsm_pkg.
module srsm_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [srsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [srsm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output srsm_pkg::cfg_t                     cfg
);
    import srsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_VALUE:   cfg_next.min_value   = cfg_wdata[SAMPLE_W-1:0];
                CFG_MAX_VALUE:   cfg_next.max_value   = cfg_wdata[SAMPLE_W-1:0];
                CFG_NOISE_FLOOR: cfg_next.noise_floor = cfg_wdata;
                CFG_SETTLE_MS:   cfg_next.settle_ms   = cfg_wdata[TIME_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value   <= MIN_VALUE_RESET;
            cfg_reg.max_value   <= MAX_VALUE_RESET;
            cfg_reg.noise_floor <= NOISE_FLOOR_RESET;
            cfg_reg.settle_ms   <= SETTLE_MS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/srsm_front.sv =====
// Input register, range check and squaring of the sample.
// Feeds the window stage over a valid/stall hop; uses srsm_pkg.
module srsm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  srsm_pkg::in_item_t   in_data,
    input  srsm_pkg::cfg_t       cfg,
    output logic                 smp_valid,
    input  logic                 smp_stall,
    output srsm_pkg::smp_t       smp
);
    import srsm_pkg::*;

    logic      s1_vld_reg;
    logic      s1_vld_next;
    in_item_t  s1_reg;
    logic      s2_vld_reg;
    logic      s2_vld_next;
    smp_t      s2_reg;
    smp_t      s2_next;

    logic                         ready1;
    logic                         ready2;
    logic                         accept;
    logic                         load2;
    logic signed [SAMPLE_W-1:0]   x;
    logic signed [2*SAMPLE_W-1:0] prod;

    assign ready2   = !s2_vld_reg || !smp_stall;
    assign load2    = s1_vld_reg && ready2;
    assign ready1   = !s1_vld_reg || load2;
    assign accept   = in_valid && ready1;
    assign in_stall = !ready1;

    assign x    = s1_reg.sample;
    assign prod = x * x;

    always_comb
    begin
        s2_next.op     = s1_reg.op;
        s2_next.bad    = s1_reg.sample_invalid || (x < $signed(cfg.min_value))
                         || (x > $signed(cfg.max_value));
        s2_next.x      = x;
        s2_next.x_sq   = prod[SQ_W-1:0];
        s2_next.now_ms = s1_reg.now_ms;
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (load2)
        begin
            s1_vld_next = 1'b0;
        end
        s2_vld_next = s2_vld_reg;
        if (load2)
        begin
            s2_vld_next = 1'b1;
        end
        else if (!smp_stall)
        begin
            s2_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= in_data;
        end
        if (load2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign smp_valid = s2_vld_reg;
    assign smp       = s2_reg;

endmodule

// ===== design/srsm_window.sv =====
// Sample ring, running sums and settle timer of the monitor.
// Updates the window state once per good sample or restart; uses srsm_pkg.
module srsm_window
#(
    parameter int DEPTH = srsm_pkg::DEPTH_DEFAULT
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          smp_valid,
    output logic                                          smp_stall,
    input  srsm_pkg::smp_t                                smp,
    input  srsm_pkg::cfg_t                                cfg,
    output logic                                          win_valid,
    input  logic                                          win_stall,
    output srsm_pkg::win_ctrl_t                           win_ctrl,
    output logic signed [srsm_pkg::sum_width(DEPTH)-1:0]  win_sum,
    output logic [srsm_pkg::sumsq_width(DEPTH)-1:0]       win_sumsq
);
    import srsm_pkg::*;

    localparam int SUM_W   = sum_width(DEPTH);
    localparam int SUMSQ_W = sumsq_width(DEPTH);
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    ring_entry_t ring_mem [DEPTH];
    ring_entry_t rd_reg;

    logic [PTR_W-1:0]        wp_reg;
    logic [PTR_W-1:0]        wp_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUMSQ_W-1:0]      sumsq_reg;
    logic [SUMSQ_W-1:0]      sumsq_next;
    logic [TIME_W-1:0]       start_reg;
    logic [TIME_W-1:0]       start_next;

    logic                    s3_vld_reg;
    logic                    s3_vld_next;
    win_ctrl_t               s3_ctrl_reg;
    win_ctrl_t               s3_ctrl_next;
    logic signed [SUM_W-1:0] s3_sum_reg;
    logic [SUMSQ_W-1:0]      s3_sumsq_reg;

    logic                       ready3;
    logic                       load3;
    logic                       upd;
    logic                       restart;
    logic                       full;
    logic signed [SAMPLE_W-1:0] old_x;
    logic [SQ_W-1:0]            old_sq;
    logic [PTR_W-1:0]           wp_inc;
    logic [CNT_W-1:0]           fill_inc;
    logic [TIME_W-1:0]          elapsed;

    assign ready3    = !s3_vld_reg || !win_stall;
    assign load3     = smp_valid && ready3;
    assign smp_stall = !ready3;
    assign restart   = load3 && (smp.op == OP_RESTART);
    assign upd       = load3 && (smp.op == OP_SAMPLE) && !smp.bad;

    // Until the ring has wrapped once, the slot being replaced reads as zero.
    assign full   = (fill_reg == CNT_W'(DEPTH));
    assign old_x  = full ? rd_reg.x : '0;
    assign old_sq = full ? rd_reg.x_sq : '0;

    assign wp_inc   = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_inc = full ? fill_reg : fill_reg + 1'b1;
    assign elapsed  = smp.now_ms - start_reg;

    always_comb
    begin
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        start_next = start_reg;
        if (restart)
        begin
            wp_next    = '0;
            fill_next  = '0;
            sum_next   = '0;
            sumsq_next = '0;
            start_next = smp.now_ms;
        end
        else if (upd)
        begin
            wp_next    = wp_inc;
            fill_next  = fill_inc;
            sum_next   = sum_reg - SUM_W'(old_x) + SUM_W'(smp.x);
            sumsq_next = sumsq_reg - SUMSQ_W'(old_sq) + SUMSQ_W'(smp.x_sq);
        end
    end

    always_comb
    begin
        s3_ctrl_next.cause = CAUSE_NONE;
        s3_ctrl_next.check = 1'b0;
        if (smp.op == OP_SAMPLE)
        begin
            if (smp.bad)
            begin
                s3_ctrl_next.cause = CAUSE_RANGE;
            end
            else
            begin
                s3_ctrl_next.check = (fill_inc == CNT_W'(DEPTH))
                                     && (elapsed >= cfg.settle_ms);
            end
        end
        s3_vld_next = s3_vld_reg;
        if (load3)
        begin
            s3_vld_next = 1'b1;
        end
        else if (!win_stall)
        begin
            s3_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
            sumsq_reg  <= '0;
            start_reg  <= '0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
            sumsq_reg  <= sumsq_next;
            start_reg  <= start_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    // The read port always fetches the slot that the next sample replaces.
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            ring_mem[wp_reg] <= '{x: smp.x, x_sq: smp.x_sq};
        end
        rd_reg <= ring_mem[wp_next];
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_ctrl_reg  <= s3_ctrl_next;
            s3_sum_reg   <= sum_next;
            s3_sumsq_reg <= sumsq_next;
        end
    end

    assign win_valid = s3_vld_reg;
    assign win_ctrl  = s3_ctrl_reg;
    assign win_sum   = s3_sum_reg;
    assign win_sumsq = s3_sumsq_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (fill_reg == '0) && (sum_reg == '0) && (sumsq_reg == '0))
        else $error("window state not cleared after restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != CNT_W'(DEPTH)) |-> (CNT_W'(wp_reg) == fill_reg))
        else $error("write pointer out of step with fill count");
`endif

endmodule

// ===== design/srsm_judge.sv =====
// Variance test and result register of the monitor.
// Squares the running sum, scales both sides and compares; uses srsm_pkg.
module srsm_judge
#(
    parameter int DEPTH = srsm_pkg::DEPTH_DEFAULT
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          win_valid,
    output logic                                          win_stall,
    input  srsm_pkg::win_ctrl_t                           win_ctrl,
    input  logic signed [srsm_pkg::sum_width(DEPTH)-1:0]  win_sum,
    input  logic [srsm_pkg::sumsq_width(DEPTH)-1:0]       win_sumsq,
    input  srsm_pkg::cfg_t                                cfg,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output srsm_pkg::out_item_t                           out_data
);
    import srsm_pkg::*;

    localparam int SUM_W    = sum_width(DEPTH);
    localparam int SUMSQ_W  = sumsq_width(DEPTH);
    localparam int MAG_SQ_W = 2 * SUM_W;
    localparam int DSQ_W    = SUMSQ_W + $clog2(DEPTH + 1);
    localparam int LHS_W    = DSQ_W + 1;
    localparam int RHS_W    = CFG_DATA_W + $clog2(DEPTH * DEPTH + 1);
    localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic                  s4_vld_reg;
    logic                  s4_vld_next;
    win_ctrl_t             s4_ctrl_reg;
    logic [MAG_SQ_W-1:0]   mag_sq_reg;
    logic [DSQ_W-1:0]      dsumsq_reg;
    logic [RHS_W-1:0]      rhs_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    out_item_t             out_data_reg;
    out_item_t             out_data_next;

    logic                  ready_out;
    logic                  load_out;
    logic                  ready4;
    logic                  load4;
    logic signed [SUM_W-1:0] neg_sum;
    logic [SUM_W-1:0]      mag;
    logic [MAG_SQ_W-1:0]   mag_sq;
    logic [DSQ_W-1:0]      dsumsq;
    logic [RHS_W-1:0]      rhs;
    logic [LHS_W-1:0]      lhs;
    logic                  stuck;

    assign ready_out = !out_vld_reg || !out_stall;
    assign load_out  = s4_vld_reg && ready_out;
    assign ready4    = !s4_vld_reg || load_out;
    assign load4     = win_valid && ready4;
    assign win_stall = !ready4;

    assign neg_sum = -win_sum;
    assign mag     = win_sum[SUM_W-1] ? neg_sum : win_sum;
    assign mag_sq  = MAG_SQ_W'(mag) * MAG_SQ_W'(mag);
    assign dsumsq  = DSQ_W'(win_sumsq) * DSQ_W'(DEPTH);
    assign rhs     = RHS_W'(cfg.noise_floor) * RHS_W'(DEPTH * DEPTH);

    // DEPTH*sumsq - sum^2 is never negative, so the difference is exact.
    assign lhs   = LHS_W'(dsumsq_reg) - LHS_W'(mag_sq_reg);
    assign stuck = s4_ctrl_reg.check && (CMP_W'(lhs) < CMP_W'(rhs_reg));

    always_comb
    begin
        out_data_next.healthy     = 1'b1;
        out_data_next.fault_cause = CAUSE_NONE;
        if (s4_ctrl_reg.cause == CAUSE_RANGE)
        begin
            out_data_next.healthy     = 1'b0;
            out_data_next.fault_cause = CAUSE_RANGE;
        end
        else if (stuck)
        begin
            out_data_next.healthy     = 1'b0;
            out_data_next.fault_cause = CAUSE_STUCK;
        end
    end

    always_comb
    begin
        s4_vld_next = s4_vld_reg;
        if (load4)
        begin
            s4_vld_next = 1'b1;
        end
        else if (load_out)
        begin
            s4_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg  <= s4_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            s4_ctrl_reg <= win_ctrl;
            mag_sq_reg  <= mag_sq;
            dsumsq_reg  <= dsumsq;
            rhs_reg     <= rhs;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !s4_ctrl_reg.check) |=> (out_data_reg.fault_cause != CAUSE_STUCK))
        else $error("stuck reported without a full, settled window");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_data_reg.healthy == (out_data_reg.fault_cause == CAUSE_NONE)))
        else $error("healthy flag disagrees with fault cause");
`endif

endmodule
